// File: design/pidtl_pkg.sv
// Shared types, register codes and arithmetic helpers for the PID controller core.
package pidtl_pkg;

	// Widths fixed by the item and register fields.
	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int COUNT_W   = 16;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int WIDE_W    = 48;

	// Input mode codes.
	localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEAS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_P = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_I = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_D = 3'd5;

	// Saturation bounds for a signed 32-bit result.
	localparam logic signed [WIDE_W-1:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_MIN = -48'sh0000_8000_0000;
	localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

	// Operation decoded by the front end.
	typedef enum logic [1:0] {
		OP_SET,
		OP_MEAS,
		OP_CLEAR,
		OP_NONE
	} op_t;

	// One queued request: decoded operation and its operand.
	typedef struct packed {
		op_t                     op;
		logic signed [DATA_W-1:0] value;
	} qent_t;

	// Configuration register set.
	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       limit_p;
		logic [LIMIT_W-1:0]       limit_i;
		logic [LIMIT_W-1:0]       limit_d;
	} cfg_t;

	// Result of a magnitude clamp.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     hit;
	} clamp_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Clamp a term to plus or minus its limit; equality is not a clamp.
	function automatic clamp_t clamp_term(input logic signed [DATA_W-1:0] v,
			input logic [LIMIT_W-1:0] lim);
		clamp_t                   r;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] neg;
		pos = signed'({1'b0, lim});
		neg = -pos;
		if (v > pos) begin
			r.value = pos;
			r.hit   = 1'b1;
		end else if (v < neg) begin
			r.value = neg;
			r.hit   = 1'b1;
		end else begin
			r.value = v;
			r.hit   = 1'b0;
		end
		return r;
	endfunction

	// Saturating counter step.
	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c, input logic hit);
		logic [COUNT_W-1:0] r;
		r = c;
		if (hit && (c != COUNT_FULL)) begin
			r = c + 1'b1;
		end
		return r;
	endfunction

endpackage

// File: design/pidtl_regs.sv
// Configuration register file for gains and term limits.
module pidtl_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pidtl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidtl_pkg::DATA_W-1:0]      cfg_data,
	output pidtl_pkg::cfg_t                   cfg
);
	import pidtl_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes by index; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p  <= '0;
			cfg_q.gain_i  <= '0;
			cfg_q.gain_d  <= '0;
			cfg_q.limit_p <= '1;
			cfg_q.limit_i <= '1;
			cfg_q.limit_d <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:  cfg_q.gain_p  <= signed'(cfg_data);
				REG_GAIN_I:  cfg_q.gain_i  <= signed'(cfg_data);
				REG_GAIN_D:  cfg_q.gain_d  <= signed'(cfg_data);
				REG_LIMIT_P: cfg_q.limit_p <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_I: cfg_q.limit_i <= cfg_data[LIMIT_W-1:0];
				REG_LIMIT_D: cfg_q.limit_d <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/pidtl_front.sv
// Front end: accepts requests, decodes the mode and queues them for the datapath.
module pidtl_front #(
	parameter int DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pidtl_pkg::MODE_W-1:0]         mode,
	input  logic signed [pidtl_pkg::DATA_W-1:0]  target_value,
	input  logic signed [pidtl_pkg::DATA_W-1:0]  measurement,
	output logic                                 q_valid,
	output pidtl_pkg::qent_t                     q_head,
	input  logic                                 q_pop
);
	import pidtl_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	qent_t            entry;
	logic             push;

	// Decode the mode and pick the operand that goes with it.
	always_comb begin
		entry.value = measurement;
		case (mode)
			MODE_SET: begin
				entry.op    = OP_SET;
				entry.value = target_value;
			end
			MODE_MEAS:  entry.op = OP_MEAS;
			MODE_CLEAR: entry.op = OP_CLEAR;
			default:    entry.op = OP_NONE;
		endcase
	end

	assign in_ready = (count_q != CNT_FULL);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_head   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The queue never overfills, and the back end never pops an empty queue.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill count exceeds depth");
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (count_q != '0))
		else $error("pop from empty queue");

endmodule

// File: design/pidtl_back.sv
// Back end: error, product, clamp and sum pipeline holding the controller state.
module pidtl_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pidtl_pkg::cfg_t                      cfg,
	input  logic                                 q_valid,
	input  pidtl_pkg::qent_t                     q_head,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pidtl_pkg::DATA_W-1:0]  control_output,
	output logic                                 target_present,
	output logic [pidtl_pkg::COUNT_W-1:0]        p_clamp_count,
	output logic [pidtl_pkg::COUNT_W-1:0]        i_clamp_count,
	output logic [pidtl_pkg::COUNT_W-1:0]        d_clamp_count
);
	import pidtl_pkg::*;

	logic en;

	// Stage one state and registers.
	logic signed [DATA_W-1:0] setpoint_q;
	logic                     sp_valid_q;
	logic signed [DATA_W-1:0] prev_err_q;
	logic signed [DATA_W-1:0] err;
	logic signed [DATA_W-1:0] diff;
	logic                     upd;
	logic                     valid_s1, upd_s1, clr_s1, present_s1;
	logic signed [DATA_W-1:0] err_s1, diff_s1;

	// Stage two registers.
	logic                         valid_s2, upd_s2, clr_s2, present_s2;
	logic signed [2*DATA_W-1:0]   prod_p_s2, prod_i_s2, prod_d_s2;

	// Stage three state and registers.
	logic signed [DATA_W-1:0] integral_q;
	logic [COUNT_W-1:0]       p_cnt_q, i_cnt_q, d_cnt_q;
	clamp_t                   pc, ic, dc;
	logic signed [DATA_W-1:0] qi;
	logic                     valid_s3, upd_s3, clr_s3, present_s3;
	logic signed [DATA_W-1:0] pt_s3, it_s3, dt_s3;

	// Output register, which also holds the drive value.
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     present_q;
	logic [COUNT_W-1:0]       p_out_q, i_out_q, d_out_q;
	logic signed [WIDE_W-1:0] total;

	// The whole pipeline moves when the output slot is free or being taken.
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;

	// Stage one: error and error change against the stored setpoint.
	assign upd  = (q_head.op == OP_MEAS) && sp_valid_q;
	assign err  = sat32(WIDE_W'(setpoint_q) - WIDE_W'(q_head.value));
	assign diff = sat32(WIDE_W'(err) - WIDE_W'(prev_err_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			sp_valid_q <= 1'b0;
			prev_err_q <= '0;
			valid_s1   <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_valid;
			if (q_valid) begin
				case (q_head.op)
					OP_SET: begin
						setpoint_q <= q_head.value;
						sp_valid_q <= 1'b1;
					end
					OP_MEAS: begin
						if (sp_valid_q) begin
							prev_err_q <= err;
						end
					end
					OP_CLEAR: begin
						sp_valid_q <= 1'b0;
						prev_err_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upd_s1     <= upd;
			clr_s1     <= (q_head.op == OP_CLEAR);
			present_s1 <= (q_head.op == OP_SET) ||
				(sp_valid_q && (q_head.op != OP_CLEAR));
			err_s1     <= err;
			diff_s1    <= diff;
		end
	end

	// Stage two: the three gain products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upd_s2     <= upd_s1;
			clr_s2     <= clr_s1;
			present_s2 <= present_s1;
			prod_p_s2  <= err_s1 * cfg.gain_p;
			prod_i_s2  <= err_s1 * cfg.gain_i;
			prod_d_s2  <= diff_s1 * cfg.gain_d;
		end
	end

	// Stage three: scale, clamp, integrate and count clamps.
	assign qi = sat32(prod_i_s2[2*DATA_W-1:16]);
	assign pc = clamp_term(sat32(prod_p_s2[2*DATA_W-1:16]), cfg.limit_p);
	assign ic = clamp_term(sat32(WIDE_W'(integral_q) + WIDE_W'(qi)), cfg.limit_i);
	assign dc = clamp_term(sat32(prod_d_s2[2*DATA_W-1:16]), cfg.limit_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			p_cnt_q    <= '0;
			i_cnt_q    <= '0;
			d_cnt_q    <= '0;
			valid_s3   <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			if (valid_s2 && clr_s2) begin
				integral_q <= '0;
				p_cnt_q    <= '0;
				i_cnt_q    <= '0;
				d_cnt_q    <= '0;
			end else if (valid_s2 && upd_s2) begin
				integral_q <= ic.value;
				p_cnt_q    <= bump(p_cnt_q, pc.hit);
				i_cnt_q    <= bump(i_cnt_q, ic.hit);
				d_cnt_q    <= bump(d_cnt_q, dc.hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upd_s3     <= upd_s2;
			clr_s3     <= clr_s2;
			present_s3 <= present_s2;
			pt_s3      <= pc.value;
			it_s3      <= ic.value;
			dt_s3      <= dc.value;
		end
	end

	// Output stage: sum the terms; the counters already hold this request's values.
	assign total = WIDE_W'(pt_s3) + WIDE_W'(it_s3) + WIDE_W'(dt_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			present_q   <= 1'b0;
			p_out_q     <= '0;
			i_out_q     <= '0;
			d_out_q     <= '0;
		end else if (en) begin
			out_valid_q <= valid_s3;
			if (valid_s3) begin
				present_q <= present_s3;
				p_out_q   <= p_cnt_q;
				i_out_q   <= i_cnt_q;
				d_out_q   <= d_cnt_q;
				if (clr_s3) begin
					drive_q <= '0;
				end else if (upd_s3) begin
					drive_q <= sat32(total);
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign control_output = drive_q;
	assign target_present = present_q;
	assign p_clamp_count  = p_out_q;
	assign i_clamp_count  = i_out_q;
	assign d_clamp_count  = d_out_q;

	// An update is only issued with a setpoint present.
	a_upd_needs_target: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && upd_s1) |-> present_s1)
		else $error("update issued without a setpoint");
	// A stalled pipeline keeps the integral.
	a_stall_holds_integral: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(integral_q))
		else $error("integral changed during a stall");
	// A clear leaving the pipeline zeroes the drive value.
	a_clear_zeroes_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3 && clr_s3) |=> (drive_q == '0))
		else $error("drive value not zero after clear");
	// A clamp counter steps by one or returns to zero.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(p_cnt_q != $past(p_cnt_q)) |->
			((p_cnt_q == '0) || (p_cnt_q == $past(p_cnt_q) + 1'b1)))
		else $error("clamp counter jumped");

endmodule

// File: design/pid_controller_with_term_limits_core.sv
// A request goes from the queue through stages one, two and three to the output register.
// Throughput: one request per cycle unless a held output stalls; the stage three integral
// add and clamp is the loop that sets it, with the three gain multipliers one stage ahead.
// A two-entry queue parts the decoder from the datapath; results wait in an output register.
// Reset: gains zero, limits at full scale, setpoint, integral, error, drive and counters zero.
// No clearing pass is needed; requests are taken from the first cycle after reset.
module pid_controller_with_term_limits_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidtl_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pidtl_pkg::MODE_W-1:0]         mode,
	input  logic signed [pidtl_pkg::DATA_W-1:0]  target_value,
	input  logic signed [pidtl_pkg::DATA_W-1:0]  measurement,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pidtl_pkg::DATA_W-1:0]  control_output,
	output logic                                 target_present,
	output logic [pidtl_pkg::COUNT_W-1:0]        p_clamp_count,
	output logic [pidtl_pkg::COUNT_W-1:0]        i_clamp_count,
	output logic [pidtl_pkg::COUNT_W-1:0]        d_clamp_count
);
	import pidtl_pkg::*;

	cfg_t  cfg;
	qent_t q_head;
	logic  q_valid;
	logic  q_pop;

	// Gain and limit registers.
	pidtl_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Request decode and queue.
	pidtl_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.target_value (target_value),
		.measurement  (measurement),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop)
	);

	// Controller datapath.
	pidtl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.control_output (control_output),
		.target_present (target_present),
		.p_clamp_count  (p_clamp_count),
		.i_clamp_count  (i_clamp_count),
		.d_clamp_count  (d_clamp_count)
	);

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the PID controller core with per-term limits.
`timescale 1ns / 1ps

module tb_top;
	import pidtl_pkg::*;

	// Mode code that the core ignores, and a register index with no register behind it.
	localparam logic [MODE_W-1:0]    MODE_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

	// Receiver stall styles.
	localparam int READY_ALWAYS   = 0;
	localparam int READY_COIN     = 1;
	localparam int READY_SPARSE   = 2;
	localparam int READY_PERIODIC = 3;

	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int COUNT_RUN     = 64;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 280;

	typedef struct {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] meas;
		logic                     drain_first;
	} pid_request_t;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     present;
		logic [COUNT_W-1:0]       p_count;
		logic [COUNT_W-1:0]       i_count;
		logic [COUNT_W-1:0]       d_count;
	} pid_result_t;

	// Ports of the core.
	logic                        clk;
	logic                        arst_n         = 1'b0;
	logic                        cfg_valid      = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index      = '0;
	logic [DATA_W-1:0]           cfg_data       = '0;
	logic                        in_valid       = 1'b0;
	logic                        in_ready;
	logic [MODE_W-1:0]           mode           = '0;
	logic signed [DATA_W-1:0]    target_value   = '0;
	logic signed [DATA_W-1:0]    measurement    = '0;
	logic                        out_valid;
	logic                        out_ready      = 1'b0;
	logic signed [DATA_W-1:0]    control_output;
	logic                        target_present;
	logic [COUNT_W-1:0]          p_clamp_count;
	logic [COUNT_W-1:0]          i_clamp_count;
	logic [COUNT_W-1:0]          d_clamp_count;

	pid_controller_with_term_limits_core dut (.*);

	// Controller registers and state as the testbench tracks them.
	logic signed [DATA_W-1:0] cfg_gain_p  = '0;
	logic signed [DATA_W-1:0] cfg_gain_i  = '0;
	logic signed [DATA_W-1:0] cfg_gain_d  = '0;
	logic [LIMIT_W-1:0]       cfg_limit_p = '1;
	logic [LIMIT_W-1:0]       cfg_limit_i = '1;
	logic [LIMIT_W-1:0]       cfg_limit_d = '1;

	logic signed [DATA_W-1:0] ctl_setpoint   = '0;
	logic                     ctl_has_target = 1'b0;
	logic signed [DATA_W-1:0] ctl_integral   = '0;
	logic signed [DATA_W-1:0] ctl_prev_err   = '0;
	logic signed [DATA_W-1:0] ctl_drive      = '0;
	logic [COUNT_W-1:0]       ctl_p_clamps   = '0;
	logic [COUNT_W-1:0]       ctl_i_clamps   = '0;
	logic [COUNT_W-1:0]       ctl_d_clamps   = '0;

	pid_request_t pending_requests[$];
	pid_result_t  predicted_outputs[$];

	int items_pushed  = 0;
	int items_taken   = 0;
	int results_seen  = 0;
	int errors        = 0;
	int idle_cycles   = 0;

	// Sender and receiver pacing.
	int burst_left = 8;
	int gap_left   = 0;
	int hold_left  = 0;
	int holds_done = 0;
	int style      = READY_ALWAYS;
	int style_left = 0;
	logic [7:0] ready_phase = '0;
	pid_request_t offered;
	pid_result_t  oldest;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturate a wide value to a signed 32-bit word.
	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[DATA_W-1:0];
	endfunction

	// Q16.16 product, floored and saturated.
	function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [63:0] prod;
		prod = 64'(a) * 64'(b);
		return sat_word(prod >>> 16);
	endfunction

	// Bound a term to plus or minus its limit; a changed value means a clamp.
	function automatic logic signed [DATA_W-1:0] clip_term(input logic signed [DATA_W-1:0] v,
			input logic [LIMIT_W-1:0] lim);
		logic signed [DATA_W-1:0] bound;
		bound = $signed({1'b0, lim});
		if (v > bound) return bound;
		if (v < -bound) return -bound;
		return v;
	endfunction

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c, input logic hit);
		return (hit && c != 16'hFFFF) ? c + 16'd1 : c;
	endfunction

	// Advance the tracked controller by one request and return the result it should give.
	function automatic pid_result_t pid_predict(input pid_request_t req);
		logic signed [DATA_W-1:0] err;
		logic signed [DATA_W-1:0] diff;
		logic signed [DATA_W-1:0] raw;
		logic signed [DATA_W-1:0] p_term;
		logic signed [DATA_W-1:0] i_term;
		logic signed [DATA_W-1:0] d_term;
		pid_result_t res;
		case (req.mode)
			MODE_SET: begin
				ctl_setpoint   = req.target;
				ctl_has_target = 1'b1;
			end
			MODE_MEAS: begin
				if (ctl_has_target) begin
					err  = sat_word(64'(ctl_setpoint) - 64'(req.meas));
					diff = sat_word(64'(err) - 64'(ctl_prev_err));
					raw = fx_mul(err, cfg_gain_p);
					p_term = clip_term(raw, cfg_limit_p);
					ctl_p_clamps = count_up(ctl_p_clamps, p_term != raw);
					raw = sat_word(64'(ctl_integral) + 64'(fx_mul(err, cfg_gain_i)));
					i_term = clip_term(raw, cfg_limit_i);
					ctl_i_clamps = count_up(ctl_i_clamps, i_term != raw);
					ctl_integral = i_term;
					raw = fx_mul(diff, cfg_gain_d);
					d_term = clip_term(raw, cfg_limit_d);
					ctl_d_clamps = count_up(ctl_d_clamps, d_term != raw);
					ctl_prev_err = err;
					ctl_drive = sat_word(64'(p_term) + 64'(i_term) + 64'(d_term));
				end
			end
			MODE_CLEAR: begin
				ctl_has_target = 1'b0;
				ctl_integral   = '0;
				ctl_prev_err   = '0;
				ctl_drive      = '0;
				ctl_p_clamps   = '0;
				ctl_i_clamps   = '0;
				ctl_d_clamps   = '0;
			end
			default: begin
			end
		endcase
		res.drive   = ctl_drive;
		res.present = ctl_has_target;
		res.p_count = ctl_p_clamps;
		res.i_count = ctl_i_clamps;
		res.d_count = ctl_d_clamps;
		return res;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("tb_top: %s", msg);
		end
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
		end
	endtask

	// Q16.16 value: mostly near zero, else full range or an extreme.
	function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned span);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return $signed($urandom_range(0, span)) - $signed(span / 2);
		if (pick < 85) return $urandom;
		case ($urandom_range(0, 4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return 32'sh1;
			default: return -32'sh1;
		endcase
	endfunction

	// Gain for a random phase: the first phase runs at full-scale gains.
	function automatic logic [DATA_W-1:0] next_gain(input int phase);
		if (phase == 0) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return pick_value(32'h0008_0000);
	endfunction

	// Limit for a random phase; the top data bit is outside the field and left random.
	function automatic logic [DATA_W-1:0] next_limit(input int phase);
		logic [DATA_W-1:0] data;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (phase == 0) data = 32'h7FFF_FFFF;
		else if (phase == 1) data = '0;
		else if (pick < 50) data = $urandom_range(0, 32'h0008_0000);
		else if (pick < 80) data = $urandom;
		else data = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
		data[DATA_W-1] = $urandom_range(0, 1);
		return data;
	endfunction

	// One register write request, waited out on its handshake.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN_P:  cfg_gain_p  = data;
			REG_GAIN_I:  cfg_gain_i  = data;
			REG_GAIN_D:  cfg_gain_d  = data;
			REG_LIMIT_P: cfg_limit_p = data[LIMIT_W-1:0];
			REG_LIMIT_I: cfg_limit_i = data[LIMIT_W-1:0];
			REG_LIMIT_D: cfg_limit_d = data[LIMIT_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic add_request(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] tgt,
			input logic signed [DATA_W-1:0] meas, input logic drain);
		pending_requests.push_back('{m, tgt, meas, drain});
		items_pushed++;
	endtask

	// Every request gives one result, so the core is idle once the counts meet.
	task automatic wait_drained();
		while (results_seen != items_pushed) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_phase(input int phase);
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_GAIN_P, next_gain(phase));
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_GAIN_I, next_gain(phase));
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_GAIN_D, next_gain(phase));
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_LIMIT_P, next_limit(phase));
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_LIMIT_I, next_limit(phase));
		if (phase < 2 || $urandom_range(0, 3) != 0) write_reg(REG_LIMIT_D, next_limit(phase));
	endtask

	// Control-loop traffic: a setpoint, then mostly measurements around it, with
	// occasional new setpoints, clears and ignored codes mixed in.
	task automatic queue_control_run(input int count);
		logic signed [DATA_W-1:0] aim;
		logic signed [DATA_W-1:0] meas;
		logic drain;
		int unsigned kind;
		int made;
		aim = pick_value(32'h0010_0000);
		add_request(MODE_SET, aim, $urandom, 1'b0);
		made = 0;
		while (made < count) begin
			kind  = $urandom_range(0, 99);
			drain = ($urandom_range(0, 149) == 0);
			if (kind < 4) begin
				add_request(MODE_IGNORED, $urandom, $urandom, drain);
			end else begin
				made++;
				if (kind < 62) begin
					meas = aim + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh1_0000);
					add_request(MODE_MEAS, $urandom, meas, drain);
				end else if (kind < 80) begin
					add_request(MODE_MEAS, $urandom, pick_value(32'h0010_0000), drain);
				end else if (kind < 92) begin
					aim = pick_value(32'h0010_0000);
					add_request(MODE_SET, aim, $urandom, drain);
				end else if (kind < 96) begin
					add_request(MODE_CLEAR, $urandom, $urandom, drain);
				end else begin
					// Clear, then restart the loop on a fresh setpoint.
					add_request(MODE_CLEAR, $urandom, $urandom, drain);
					aim = pick_value(32'h0010_0000);
					add_request(MODE_SET, aim, $urandom, 1'b0);
					made++;
				end
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		logic signed [DATA_W-1:0] mag;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: no setpoint, ignored code, saturated error, clear.
		add_request(MODE_MEAS, $urandom, 32'sh7FFF_FFFF, 1'b0);
		add_request(MODE_IGNORED, $urandom, $urandom, 1'b0);
		add_request(MODE_SET, 32'sh7FFF_FFFF, $urandom, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh8000_0000, 1'b0);
		add_request(MODE_CLEAR, $urandom, $urandom, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh0001_2345, 1'b0);
		wait_drained();

		// Full-scale P and I gains, a unity D gain, a zero P limit and a D limit that is hit exactly.
		write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
		write_reg(REG_GAIN_I, 32'h8000_0000);
		write_reg(REG_GAIN_D, 32'h0001_0000);
		write_reg(REG_LIMIT_P, 32'h8000_0000);
		write_reg(REG_LIMIT_I, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT_D, 32'h0003_0000);
		write_reg(REG_UNUSED, $urandom);
		add_request(MODE_SET, 32'sh8000_0000, $urandom, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh7FFF_FFFF, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh8000_0000, 1'b0);
		add_request(MODE_SET, 32'sh0, $urandom, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh0, 1'b0);
		// Error steps by exactly the D limit, so the D term equals it without a clamp.
		add_request(MODE_MEAS, $urandom, -32'sh3_0000, 1'b0);
		add_request(MODE_MEAS, $urandom, -32'sh3_0001, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh1, 1'b0);
		add_request(MODE_IGNORED, $urandom, $urandom, 1'b0);
		add_request(MODE_CLEAR, $urandom, $urandom, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh1234_5678, 1'b0);
		add_request(MODE_SET, 32'sh0005_0000, $urandom, 1'b1);
		add_request(MODE_MEAS, $urandom, 32'sh0005_0000, 1'b0);
		add_request(MODE_MEAS, $urandom, 32'sh7FFF_FFFF, 1'b0);
		wait_drained();

		// Random phases, each under its own register settings.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure_phase(phase);
			queue_control_run(PHASE_ITEMS);
			wait_drained();
		end

		// Zero limits and unity gains: every measurement clamps all three terms,
		// so each counter steps on every measurement of the run.
		write_reg(REG_GAIN_P, 32'h0001_0000);
		write_reg(REG_GAIN_I, 32'h0001_0000);
		write_reg(REG_GAIN_D, 32'h0001_0000);
		write_reg(REG_LIMIT_P, {$urandom_range(0, 1) == 1, 31'h0});
		write_reg(REG_LIMIT_I, {$urandom_range(0, 1) == 1, 31'h0});
		write_reg(REG_LIMIT_D, {$urandom_range(0, 1) == 1, 31'h0});
		add_request(MODE_SET, 32'sh0, $urandom, 1'b0);
		for (int k = 0; k < COUNT_RUN; k++) begin
			mag = $urandom_range(1, 32'h7FFF_FFFF);
			add_request(MODE_MEAS, $urandom, (k % 2 == 1) ? -mag : mag, 1'b0);
		end
		add_request(MODE_CLEAR, $urandom, $urandom, 1'b0);
		add_request(MODE_SET, pick_value(32'h0010_0000), $urandom, 1'b0);
		for (int k = 0; k < 6; k++) begin
			add_request(MODE_MEAS, $urandom, pick_value(32'h0010_0000), 1'b0);
		end
		wait_drained();

		if (predicted_outputs.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", predicted_outputs.size()));
		end
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Request driver: bursts of random length with random gaps; an item marked
	// drain_first is held back until every earlier result has come.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_outputs.push_back(pid_predict('{mode, target_value, measurement, 1'b0}));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() == 0 ||
						(pending_requests[0].drain_first && results_seen != items_taken)) begin
					in_valid <= 1'b0;
				end else begin
					offered = pending_requests.pop_front();
					mode         <= offered.mode;
					target_value <= offered.target;
					measurement  <= offered.meas;
					in_valid     <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
					end
				end
			end
		end
	end

	// Result monitor and receiver stalls, with two long hold-offs mid-run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (predicted_outputs.size() == 0) begin
					flag_error($sformatf("unexpected result, control_output %h", control_output));
				end else begin
					oldest = predicted_outputs.pop_front();
					check_field("control_output", oldest.drive, control_output);
					check_field("target_present", 32'(oldest.present), 32'(target_present));
					check_field("p_clamp_count", 32'(oldest.p_count), 32'(p_clamp_count));
					check_field("i_clamp_count", 32'(oldest.i_count), 32'(i_clamp_count));
					check_field("d_clamp_count", 32'(oldest.d_count), 32'(d_clamp_count));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done < 2 && results_seen >= 500 + 900 * holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = $urandom_range(READY_ALWAYS, READY_PERIODIC);
					style_left = $urandom_range(32, 256);
				end
				style_left--;
				ready_phase++;
				case (style)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN:   out_ready <= $urandom_range(0, 1);
					READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:      out_ready <= ready_phase[2];
				endcase
			end
		end
	end

	// Watchdog on cycles with no handshake on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

endmodule
